// ===== sv/pcmsp_pkg.sv =====
package pcmsp_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  localparam logic [1:0] CFG_BANK_SHIFT = 2'd0;
  localparam logic [1:0] CFG_BANK_MASK  = 2'd1;
  localparam logic [1:0] CFG_STEP_SCALE = 2'd2;

  localparam logic [10:0] OFS_LVOL  = 11'h002;
  localparam logic [10:0] OFS_RVOL  = 11'h003;
  localparam logic [10:0] OFS_LOOPL = 11'h004;
  localparam logic [10:0] OFS_LOOPH = 11'h005;
  localparam logic [10:0] OFS_END   = 11'h006;
  localparam logic [10:0] OFS_PITCH = 11'h007;
  localparam logic [10:0] OFS_ADRL  = 11'h084;
  localparam logic [10:0] OFS_ADRH  = 11'h085;
  localparam logic [10:0] OFS_CTL   = 11'h086;

  typedef enum logic [3:0] {
    RA_NONE = 4'd0,
    RA_HOST = 4'd1,
    RA_CTL  = 4'd2,
    RA_ADRH = 4'd3,
    RA_ADRL = 4'd4,
    RA_END  = 4'd5,
    RA_LOOPH = 4'd6,
    RA_LOOPL = 4'd7,
    RA_PITCH = 4'd8,
    RA_LVOL = 4'd9,
    RA_RVOL = 4'd10
  } rsel_t;

  typedef enum logic [2:0] {
    WA_NONE = 3'd0,
    WA_HOST = 3'd1,
    WA_CTL  = 3'd2,
    WA_ADRL = 3'd3,
    WA_ADRH = 3'd4
  } wsel_t;

  typedef struct packed {
    logic       clear;
    logic       clr_done;
    rsel_t      rsel;
    wsel_t      wsel;
    logic [3:0] ch;
    logic       cap_rd;
    logic       lat;
    logic       eval;
    logic       rom_rd;
    logic       mac;
    logic       adv;
    logic       stop;
    logic       rom_wr;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic ctl_stop;
    logic at_end;
    logic no_loop;
    logic clr_last;
  } sts_t;

endpackage

// ===== sv/pcmsp_datapath.sv =====
module pcmsp_datapath import pcmsp_pkg::*; #(
  parameter int ROM_ADDR_BITS = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [10:0] in_reg_address,
  input  logic [7:0]  in_write_data,
  input  logic [ROM_ADDR_BITS-1:0] in_rom_address,
  input  logic [4:0]  bank_shift,
  input  logic [7:0]  bank_mask,
  input  logic [23:0] step_scale,
  output logic [7:0]  rd_byte,
  output logic signed [15:0] lmix,
  output logic signed [15:0] rmix
);

  logic [7:0] regs [2048];
  logic [7:0] rom [2**ROM_ADDR_BITS];
  logic [7:0] low_r [16];
  logic [10:0] clr_r;

  logic [10:0] raddr, waddr;
  logic [7:0] wdata, q_r, romq_r;
  logic [10:0] cb;
  logic [7:0] ctl_r, end_r, lvol_r, rvol_r, pitch_r, lph_r, lpl_r;
  logic [23:0] addr_r;
  logic [23:0] addr_adv;
  logic signed [23:0] lsum_r, rsum_r;
  logic [ROM_ADDR_BITS-1:0] ridx;
  logic [55:0] base;
  logic [31:0] stepm;
  logic signed [8:0] sv;
  logic signed [17:0] lp, rp;

  assign cb = {3'd0, cmd.ch, 3'd0};

  always_comb begin
    unique case (cmd.rsel)
      RA_HOST:  raddr = in_reg_address;
      RA_CTL:   raddr = cb + OFS_CTL;
      RA_ADRH:  raddr = cb + OFS_ADRH;
      RA_ADRL:  raddr = cb + OFS_ADRL;
      RA_END:   raddr = cb + OFS_END;
      RA_LOOPH: raddr = cb + OFS_LOOPH;
      RA_LOOPL: raddr = cb + OFS_LOOPL;
      RA_PITCH: raddr = cb + OFS_PITCH;
      RA_LVOL:  raddr = cb + OFS_LVOL;
      RA_RVOL:  raddr = cb + OFS_RVOL;
      default:  raddr = in_reg_address;
    endcase
    unique case (cmd.wsel)
      WA_CTL:  begin waddr = cb + OFS_CTL;  wdata = ctl_r | 8'h01; end
      WA_ADRL: begin waddr = cb + OFS_ADRL; wdata = addr_r[15:8]; end
      WA_ADRH: begin waddr = cb + OFS_ADRH; wdata = addr_r[23:16]; end
      default: begin waddr = in_reg_address; wdata = in_write_data; end
    endcase
    if (cmd.clear) begin
      waddr = clr_r;
      wdata = 8'hff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.wsel != WA_NONE) regs[waddr] <= wdata;
    q_r <= regs[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear) clr_r <= clr_r + 11'd1;
    else if (cmd.clr_done) clr_r <= '0;
  end
  assign sts.clr_last = (clr_r == 11'h7ff);

  assign base = 56'(ctl_r & bank_mask) << bank_shift;
  assign ridx = ROM_ADDR_BITS'(base + 56'(addr_r[23:8]));

  always_ff @(posedge clk) begin
    if (cmd.rom_wr) rom[in_rom_address] <= in_write_data;
    if (cmd.rom_rd) romq_r <= rom[ridx];
  end

  assign addr_adv = addr_r + stepm[23:0];

  // Register reads are registered: rsel picks the address and q_r holds the byte read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) low_r[i] <= '0;
    end else if (cmd.stop) begin
      low_r[cmd.ch] <= '0;
    end else if (cmd.adv) begin
      low_r[cmd.ch] <= addr_adv[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat) begin
      unique case (cmd.rsel)
        RA_ADRH:  ctl_r <= q_r;
        RA_ADRL:  addr_r[23:16] <= q_r;
        RA_END:   begin addr_r[15:8] <= q_r; addr_r[7:0] <= low_r[cmd.ch]; end
        RA_LOOPH: end_r <= q_r + 8'd1;
        RA_LOOPL: lph_r <= q_r;
        RA_PITCH: lpl_r <= q_r;
        RA_LVOL:  pitch_r <= q_r;
        RA_RVOL:  lvol_r <= q_r;
        default:  rvol_r <= q_r;
      endcase
    end
    if (cmd.eval && addr_r[23:16] == end_r && !ctl_r[1]) addr_r <= {lph_r, lpl_r, 8'd0};
    if (cmd.adv) addr_r <= addr_adv;
    if (cmd.cap_rd) rd_byte <= q_r;
  end

  // stepm: registered product of pitch and scale
  logic [31:0] prod_r;
  always_ff @(posedge clk) prod_r <= 32'((40'(pitch_r) * 40'(step_scale)) >> 16);
  assign stepm = prod_r;

  assign sts.ctl_stop = ctl_r[0];
  assign sts.at_end = addr_r[23:16] == end_r;
  assign sts.no_loop = ctl_r[1];

  assign sv = $signed({1'b0, romq_r}) - 9'sd128;
  assign lp = sv * $signed({1'b0, lvol_r});
  assign rp = sv * $signed({1'b0, rvol_r});

  always_ff @(posedge clk) begin
    if (cmd.fin || !rst_n) begin
      lsum_r <= '0;
      rsum_r <= '0;
    end else if (cmd.mac) begin
      lsum_r <= lsum_r + 24'(lp);
      rsum_r <= rsum_r + 24'(rp);
    end
  end

  function automatic logic signed [15:0] sat(input logic signed [23:0] x);
    if (x > 24'sd32767) return 16'sd32767;
    if (x < -24'sd32768) return -16'sd32768;
    return x[15:0];
  endfunction

  assign lmix = sat(lsum_r);
  assign rmix = sat(rsum_r);

endmodule

// ===== sv/pcmsp_ctrl.sv =====
module pcmsp_ctrl import pcmsp_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       res_rd,
  output logic       res_tick,
  output cmd_t       cmd,
  input  sts_t       sts
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_EVAL = 7'b0010000,
    S_PLAY = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] ch_r, ch_nxt;
  logic [3:0] k_r, k_nxt;
  logic out_valid_r, out_valid_nxt;
  logic rd_r, rd_nxt, tk_r, tk_nxt;

  localparam logic [3:0] LAST_CH = 4'(CHANNELS - 1);

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res_rd = rd_r;
  assign res_tick = tk_r;

  // Fetch schedule: k selects register, latched later from the registered read q_r
  function automatic rsel_t fsel(input logic [3:0] k);
    unique case (k)
      4'd0: return RA_CTL;
      4'd1: return RA_ADRH;
      4'd2: return RA_ADRL;
      4'd3: return RA_END;
      4'd4: return RA_LOOPH;
      4'd5: return RA_LOOPL;
      4'd6: return RA_PITCH;
      4'd7: return RA_LVOL;
      4'd8: return RA_RVOL;
      default: return RA_NONE;
    endcase
  endfunction

  always_comb begin
    state_nxt = state_r;
    ch_nxt = ch_r;
    k_nxt = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_nxt = rd_r;
    tk_nxt = tk_r;
    cmd = '0;
    cmd.ch = ch_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          rd_nxt = 1'b0;
          tk_nxt = 1'b0;
          unique case (op_t'(in_operation))
            OP_WRITE: begin cmd.wsel = WA_HOST; out_valid_nxt = 1'b1; end
            OP_READ:  begin cmd.rsel = RA_HOST; state_nxt = S_RD; end
            OP_LOAD:  begin cmd.rom_wr = 1'b1; out_valid_nxt = 1'b1; end
            default: begin
              cmd.fin = 1'b1;
              ch_nxt = '0;
              k_nxt = '0;
              state_nxt = S_FETCH;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.cap_rd = 1'b1;
        rd_nxt = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FETCH: begin
        // k: issue read of item k, latch item k-1 (tag via rsel of k)
        cmd.rsel = fsel(k_r);
        cmd.lat = (k_r != 4'd0);
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd9) begin
          cmd.rsel = RA_NONE;
          state_nxt = S_EVAL;
        end
        if (k_r == 4'd2 && sts.ctl_stop) begin
          cmd.lat = 1'b0;
          state_nxt = S_PLAY;
          k_nxt = 4'd15;
        end
      end
      S_EVAL: begin
        // end page check; reload takes the latched loop address
        cmd.eval = 1'b1;
        if (sts.at_end && sts.no_loop) begin
          cmd.stop = 1'b1;
          cmd.wsel = WA_CTL;
          k_nxt = 4'd15;
        end else begin
          k_nxt = 4'd0;
        end
        state_nxt = S_PLAY;
      end
      S_PLAY: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd15) begin
          k_nxt = 4'd0;
          if (ch_r == LAST_CH) begin
            tk_nxt = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            ch_nxt = ch_r + 4'd1;
            state_nxt = S_FETCH;
          end
        end else begin
          unique case (k_r)
            4'd0: cmd.rom_rd = 1'b1;
            4'd1: cmd.mac = 1'b1;
            4'd2: begin cmd.adv = 1'b1; end
            4'd3: cmd.wsel = WA_ADRL;
            4'd4: begin cmd.wsel = WA_ADRH; k_nxt = 4'd15; end
            default: k_nxt = 4'd15;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ch_r <= '0;
      k_r <= '0;
      out_valid_r <= 1'b0;
      rd_r <= 1'b0;
      tk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r <= ch_nxt;
      k_r <= k_nxt;
      out_valid_r <= out_valid_nxt;
      rd_r <= rd_nxt;
      tk_r <= tk_nxt;
    end
  end

  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ready) else $error("accept during clear");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r) else $error("result dropped");

endmodule

// ===== sv/pcm_sample_player_16ch.sv =====
// 16-channel PCM sample player.
// Input channel (in_valid/in_ready): operation, reg_address, write_data,
// rom_address. Every transaction yields exactly one result on the output
// channel (out_valid/out_ready): read_data, left_sample, right_sample.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets bank_shift,
// bank_mask and step_scale; write only while idle.
// A register write or ROM load answers straight from idle; a register read
// first passes the read state. A tick fetches each playing channel's
// registers over the single register RAM port, checks the end page, reads
// the sample, mixes and writes the address back, and steps on; a channel
// that stops at its end page skips the sample, and one already stopped also
// skips the rest of its fetch and the end page check.
// After reset a clearing pass sets all 2048 register bytes to 0xff, one byte
// per cycle; no input is accepted until the pass is done. Config is always accepted.
// A stalled result holds on the output; a new transaction is taken once the
// result is taken in the same cycle or earlier.
module pcm_sample_player_16ch import pcmsp_pkg::*; #(
  parameter int ROM_ADDR_BITS = 17,
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [10:0] in_reg_address,
  input  logic [7:0]  in_write_data,
  input  logic [ROM_ADDR_BITS-1:0] in_rom_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic res_rd, res_tick;
  logic [7:0] rd_byte;
  logic signed [15:0] lmix, rmix;
  logic [4:0]  bank_shift_r;
  logic [7:0]  bank_mask_r;
  logic [23:0] step_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_shift_r <= 5'd16;
      bank_mask_r <= 8'h70;
      step_scale_r <= 24'h010000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BANK_SHIFT: bank_shift_r <= cfg_data[4:0];
        CFG_BANK_MASK:  bank_mask_r <= cfg_data[7:0];
        CFG_STEP_SCALE: step_scale_r <= cfg_data;
        default: begin end
      endcase
    end
  end

  pcmsp_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation,
    .out_valid, .out_ready, .res_rd, .res_tick, .cmd, .sts
  );

  pcmsp_datapath #(.ROM_ADDR_BITS(ROM_ADDR_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_reg_address, .in_write_data, .in_rom_address,
    .bank_shift(bank_shift_r), .bank_mask(bank_mask_r), .step_scale(step_scale_r),
    .rd_byte, .lmix, .rmix
  );

  assign out_read_data = res_rd ? rd_byte : 8'd0;
  assign out_left_sample = res_tick ? lmix : 16'sd0;
  assign out_right_sample = res_tick ? rmix : 16'sd0;

endmodule
